// ===== rtl/core/eic_pkg.sv =====
// Shared types and constants of the edge interval capture queue.
package eic_pkg;

	localparam int INTERVAL_W = 16;
	localparam int TIME_W     = 32;
	localparam int FILL_W     = 10;
	localparam int ADDR_W     = 16;
	localparam int CQ_DEPTH   = 2;
	localparam int OQ_DEPTH   = 4;

	typedef enum logic [1:0] {
		KIND_EDGE   = 2'd0,
		KIND_INJECT = 2'd1,
		KIND_POP    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t               op;
		logic [ADDR_W-1:0]     addr;
		logic [INTERVAL_W-1:0] data;
		logic                  dropped;
		logic [FILL_W-1:0]     fill;
	} cmd_t;

	typedef struct packed {
		logic [INTERVAL_W-1:0] interval;
		logic                  valid;
		logic                  dropped;
		logic [FILL_W-1:0]     fill;
	} res_t;

endpackage

// ===== rtl/core/edge_interval_capture_fifo_top.sv =====
// Top level of the edge interval capture queue.
//
// Each item is an edge event, an injected test interval or a pop, and every
// item gives exactly one result. An edge queues the low 16 bits of its
// timestamp minus the previous edge or inject timestamp; an inject queues the
// given interval; both update the stored timestamp even when the buffer of
// BUFFER_DEPTH entries is full, in which case the write is dropped and the
// result flags it. A pop returns the oldest interval with interval_valid set,
// or zero with interval_valid clear when nothing is queued. fill_level is the
// count after the item, in 10 bits. Both sides transfer one item per clock:
// a new item is taken every cycle while the consumer keeps up, and its result
// passes through the command queue, the buffer RAM stage and the result queue
// on its way out. The buffer RAM performs one write or one registered read
// per cycle. The front end resolves indices and counts at the input transfer;
// a two-entry command queue and a four-entry result queue let either side
// stall alone. The buffer needs no clearing after reset.
module edge_interval_capture_fifo_top import eic_pkg::*; #(
	parameter int BUFFER_DEPTH = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            kind,
	input  logic [TIME_W-1:0]     timestamp_us,
	input  logic [INTERVAL_W-1:0] injected_interval,
	output logic                  empty,
	input  logic                  pop,
	output logic [INTERVAL_W-1:0] interval_out,
	output logic                  interval_valid,
	output logic                  write_dropped,
	output logic [FILL_W-1:0]     fill_level
);

	localparam int CCNT_W = $clog2(CQ_DEPTH + 1);

	logic                  accept;
	cmd_t                  cmd_in;
	logic [$bits(cmd_t)-1:0] cmd_head;
	logic                  cmd_empty;
	logic                  cmd_pop;
	logic [CCNT_W-1:0]     cmd_cnt;
	res_t                  res;

	// Take an item whenever the command queue has a free slot.
	assign accept = push && !full;

	eic_front #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.kind             (kind),
		.timestamp_us     (timestamp_us),
		.injected_interval(injected_interval),
		.cmd              (cmd_in)
	);

	// Decouple classification from buffer access.
	eic_queue #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CQ_DEPTH)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (accept),
		.wdata (cmd_in),
		.pop   (cmd_pop),
		.rdata (cmd_head),
		.full  (full),
		.empty (cmd_empty),
		.count (cmd_cnt)
	);

	eic_back #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty || (cmd_cnt == '0)),
		.cmd      (cmd_t'(cmd_head)),
		.cmd_pop  (cmd_pop),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	// Drive the result ports from the head of the result queue.
	assign interval_out   = res.interval;
	assign interval_valid = res.valid;
	assign write_dropped  = res.dropped;
	assign fill_level     = res.fill;

endmodule

// ===== rtl/core/eic_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module eic_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/eic_queue.sv =====
// Small register queue with the head shown combinationally.
module eic_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty,
	output logic [CNT_W-1:0] count
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign rdata   = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/core/eic_front.sv =====
// Front end: accepts items, computes intervals and keeps queue bookkeeping.
module eic_front import eic_pkg::*; #(
	parameter int BUFFER_DEPTH = 512,
	localparam int IDX_W = $clog2(BUFFER_DEPTH),
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [1:0]            kind,
	input  logic [TIME_W-1:0]     timestamp_us,
	input  logic [INTERVAL_W-1:0] injected_interval,
	output cmd_t                  cmd
);

	logic [IDX_W-1:0]  wr_idx_q, wr_idx_d;
	logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [TIME_W-1:0] last_ts_q, last_ts_d;
	logic [TIME_W-1:0] delta;
	logic              store_full;
	logic              store_empty;

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	assign delta       = timestamp_us - last_ts_q;
	assign store_full  = (cnt_q == CNT_W'(BUFFER_DEPTH));
	assign store_empty = (cnt_q == '0);

	always_comb begin
		wr_idx_d    = wr_idx_q;
		rd_idx_d    = rd_idx_q;
		cnt_d       = cnt_q;
		last_ts_d   = last_ts_q;
		cmd         = '0;
		cmd.op      = CMD_NONE;
		case (kind)
			KIND_EDGE, KIND_INJECT: begin
				last_ts_d = timestamp_us;
				cmd.data  = (kind == KIND_EDGE) ? delta[INTERVAL_W-1:0] : injected_interval;
				if (store_full) begin
					cmd.dropped = 1'b1;
				end else begin
					cmd.op   = CMD_WRITE;
					cmd.addr = ADDR_W'(wr_idx_q);
					wr_idx_d = idx_next(wr_idx_q);
					cnt_d    = cnt_q + CNT_W'(1);
				end
			end
			KIND_POP: begin
				if (!store_empty) begin
					cmd.op   = CMD_READ;
					cmd.addr = ADDR_W'(rd_idx_q);
					rd_idx_d = idx_next(rd_idx_q);
					cnt_d    = cnt_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
		cmd.fill = FILL_W'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q  <= '0;
			rd_idx_q  <= '0;
			cnt_q     <= '0;
			last_ts_q <= '0;
		end else if (accept) begin
			wr_idx_q  <= wr_idx_d;
			rd_idx_q  <= rd_idx_d;
			cnt_q     <= cnt_d;
			last_ts_q <= last_ts_d;
		end
	end

endmodule

// ===== rtl/core/eic_back.sv =====
// Back end: executes buffer writes and reads and queues the results.
module eic_back import eic_pkg::*; #(
	parameter int BUFFER_DEPTH = 512,
	localparam int IDX_W  = $clog2(BUFFER_DEPTH),
	localparam int OCNT_W = $clog2(OQ_DEPTH + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_empty,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic pop,
	output logic empty,
	output res_t res
);

	logic                  valid_s1;
	cmd_op_t               op_s1;
	logic                  dropped_s1;
	logic [FILL_W-1:0]     fill_s1;
	logic [INTERVAL_W-1:0] rdata;
	logic [OCNT_W-1:0]     oq_cnt;
	logic [OCNT_W:0]       committed;
	logic                  oq_full;
	logic                  room;
	res_t                  res_s2;
	logic [$bits(res_t)-1:0] oq_head;

	// Reserve an output slot for the access already in flight.
	assign committed = {1'b0, oq_cnt} + (OCNT_W + 1)'(valid_s1);
	assign room      = committed < (OCNT_W + 1)'(OQ_DEPTH);
	assign cmd_pop   = !cmd_empty && room;

	eic_ram #(
		.WIDTH(INTERVAL_W),
		.DEPTH(BUFFER_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd_pop && (cmd.op == CMD_WRITE)),
		.waddr(cmd.addr[IDX_W-1:0]),
		.wdata(cmd.data),
		.re   (cmd_pop && (cmd.op == CMD_READ)),
		.raddr(cmd.addr[IDX_W-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			op_s1      <= cmd.op;
			dropped_s1 <= cmd.dropped;
			fill_s1    <= cmd.fill;
		end
	end

	always_comb begin
		res_s2.valid    = (op_s1 == CMD_READ);
		res_s2.interval = res_s2.valid ? rdata : '0;
		res_s2.dropped  = dropped_s1;
		res_s2.fill     = fill_s1;
	end

	eic_queue #(
		.WIDTH($bits(res_t)),
		.DEPTH(OQ_DEPTH)
	) u_out_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (valid_s1),
		.wdata (res_s2),
		.pop   (pop),
		.rdata (oq_head),
		.full  (oq_full),
		.empty (empty),
		.count (oq_cnt)
	);

	always_comb begin
		res = res_t'(oq_head);
		// Room is reserved ahead of every push, so a full queue never sees one.
		if (oq_full && empty) begin
			res = '0;
		end
	end

endmodule
